/* rtl/tads_pkg.sv */
// Shared types, constants and table functions for the tilt-aimed dual stepper driver.
// No dependencies; used by every module in rtl/.
package tads_pkg;

	localparam int WidthBits  = 16;
	localparam int TiltBits   = 14;
	localparam int IdxBits    = 4;
	localparam int TableSize  = 11;
	localparam int Center     = TableSize / 2;
	localparam int YawPhBits  = 7;
	localparam int PitPhBits  = 5;

	// n / 10 == (n * 52429) >> 19, exact for every n below 2^16
	localparam logic [WidthBits-1:0] Div10Mul   = 16'd52429;
	localparam int                   Div10Shift = 19;

	localparam logic signed [TiltBits-1:0] AimLo  = -14'sd5;
	localparam logic signed [TiltBits-1:0] AimHi  = 14'sd5;
	localparam logic signed [TiltBits-1:0] TiltP1 = 14'sd1;
	localparam logic signed [TiltBits-1:0] TiltM1 = -14'sd1;

	// register indexes (byte address / 4)
	localparam logic [2:0] REG_RIGHT_MIN = 3'd0;
	localparam logic [2:0] REG_RIGHT_MAX = 3'd1;
	localparam logic [2:0] REG_LEFT_MIN  = 3'd2;
	localparam logic [2:0] REG_LEFT_MAX  = 3'd3;
	localparam logic [2:0] REG_AIM_DEC   = 3'd4;
	localparam logic [2:0] REG_YAW_HALF  = 3'd5;

	typedef enum logic [1:0] {
		REQ_RIGHT = 2'd0,
		REQ_LEFT  = 2'd1,
		REQ_TICK  = 2'd2,
		REQ_NONE  = 2'd3
	} req_kind_t;

	typedef struct packed {
		logic [WidthBits-1:0] right_min;
		logic [WidthBits-1:0] right_max;
		logic [WidthBits-1:0] left_min;
		logic [WidthBits-1:0] left_max;
		logic [3:0]           aim_dec;
		logic                 yaw_half;
	} cfg_t;

	// classified request, front to back
	typedef struct packed {
		req_kind_t            kind;
		logic                 in_window;
		logic [WidthBits-1:0] width;
	} item_t;

	// result, packed so that yaw_coils sits in the lowest bits
	typedef struct packed {
		logic [4:0]                  pad;
		logic [IdxBits-1:0]          aim_index;
		logic signed [TiltBits-1:0]  tilt;
		logic [WidthBits-1:0]        left_width;
		logic [WidthBits-1:0]        right_width;
		logic                        busy_res;
		logic [3:0]                  pitch_coils;
		logic [3:0]                  yaw_coils;
	} res_t;

	function automatic logic signed [3:0] yaw_tab(input logic [IdxBits-1:0] idx);
		logic signed [3:0] v;
		unique case (idx)
			4'd0:    v = -4'sd4;
			4'd1:    v = -4'sd3;
			4'd2:    v = -4'sd2;
			4'd3:    v = -4'sd1;
			4'd4:    v = -4'sd1;
			4'd5:    v = 4'sd0;
			4'd6:    v = 4'sd1;
			4'd7:    v = 4'sd1;
			4'd8:    v = 4'sd2;
			4'd9:    v = 4'sd3;
			4'd10:   v = 4'sd4;
			default: v = 4'sd0;
		endcase
		return v;
	endfunction

	function automatic logic signed [3:0] pitch_tab(input logic [IdxBits-1:0] idx);
		logic signed [3:0] v;
		unique case (idx)
			4'd0, 4'd10: v = 4'sd4;
			4'd1, 4'd9:  v = 4'sd3;
			4'd2, 4'd8:  v = 4'sd2;
			4'd3, 4'd7:  v = 4'sd1;
			default:     v = 4'sd0;
		endcase
		return v;
	endfunction

	// cw = 1: 8,A,2,6,4,5,1,9   cw = 0: 1,5,4,6,2,A,8,9
	function automatic logic [3:0] half_pat(input logic cw, input logic [2:0] p);
		logic [3:0] v;
		unique case (p)
			3'd0: v = cw ? 4'h8 : 4'h1;
			3'd1: v = cw ? 4'hA : 4'h5;
			3'd2: v = cw ? 4'h2 : 4'h4;
			3'd3: v = 4'h6;
			3'd4: v = cw ? 4'h4 : 4'h2;
			3'd5: v = cw ? 4'h5 : 4'hA;
			3'd6: v = cw ? 4'h1 : 4'h8;
			3'd7: v = 4'h9;
		endcase
		return v;
	endfunction

	// cw = 1: 6,5,9,A   cw = 0: 9,5,6,A
	function automatic logic [3:0] full_pat(input logic cw, input logic [1:0] p);
		logic [3:0] v;
		unique case (p)
			2'd0: v = cw ? 4'h6 : 4'h9;
			2'd1: v = 4'h5;
			2'd2: v = cw ? 4'h9 : 4'h6;
			2'd3: v = 4'hA;
		endcase
		return v;
	endfunction

endpackage

/* rtl/tads_front.sv */
// Front end: decodes the request kind and checks the echo width against its window.
// Depends on tads_pkg.
module tads_front (
	input  tads_pkg::cfg_t                    cfg,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [1:0]                        s_axis_tuser,
	input  logic [tads_pkg::WidthBits-1:0]    s_axis_tdata,
	input  logic                              q_full,
	output logic                              push,
	output tads_pkg::item_t                   item
);

	tads_pkg::req_kind_t kind;
	logic                lo_ok;
	logic                hi_ok;

	assign kind = tads_pkg::req_kind_t'(s_axis_tuser);

	always_comb begin
		lo_ok = 1'b0;
		hi_ok = 1'b0;
		unique case (kind)
			tads_pkg::REQ_RIGHT: begin
				lo_ok = s_axis_tdata > cfg.right_min;
				hi_ok = s_axis_tdata < cfg.right_max;
			end
			tads_pkg::REQ_LEFT: begin
				lo_ok = s_axis_tdata > cfg.left_min;
				hi_ok = s_axis_tdata < cfg.left_max;
			end
			default: begin
				lo_ok = 1'b0;
				hi_ok = 1'b0;
			end
		endcase
	end

	assign item.kind      = kind;
	assign item.in_window = lo_ok && hi_ok;
	assign item.width     = s_axis_tdata;

	assign s_axis_tready = !q_full;
	assign push          = s_axis_tvalid && !q_full;

endmodule

/* rtl/tads_queue.sv */
// Short request queue between front and back ends.
// Depends on tads_pkg.
module tads_queue #(
	parameter int Depth = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  tads_pkg::item_t wdata,
	output logic            full,
	input  logic            pop,
	output logic            rvalid,
	output tads_pkg::item_t rdata
);

	localparam int PtrBits = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntBits = $clog2(Depth + 1);
	localparam logic [PtrBits-1:0] LastPtr = PtrBits'(Depth - 1);
	localparam logic [CntBits-1:0] DepthC  = CntBits'(Depth);

	tads_pkg::item_t    mem_q [Depth];
	logic [PtrBits-1:0] wptr_q;
	logic [PtrBits-1:0] rptr_q;
	logic [CntBits-1:0] cnt_q;

	assign full   = (cnt_q == DepthC);
	assign rvalid = (cnt_q != '0);
	assign rdata  = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == LastPtr) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == LastPtr) ? '0 : rptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* rtl/tads_back.sv */
// Back end: held widths, tilt, aiming, phase counters, coil registers and result register.
// Depends on tads_pkg.
module tads_back (
	input  logic            clk,
	input  logic            arst_n,
	input  tads_pkg::cfg_t  cfg,
	input  logic            q_valid,
	input  tads_pkg::item_t item,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_ready,
	output tads_pkg::res_t  res
);

	localparam int W  = tads_pkg::WidthBits;
	localparam int TB = tads_pkg::TiltBits;
	localparam int IB = tads_pkg::IdxBits;
	localparam int YB = tads_pkg::YawPhBits;
	localparam int PB = tads_pkg::PitPhBits;

	logic [W-1:0]         right_q, right_n;
	logic [W-1:0]         left_q, left_n;
	logic [3:0]           cnt_q, cnt_n;
	logic signed [TB-1:0] tilt_q, tilt_n;
	logic [IB-1:0]        yaw_prev_q, yaw_prev_n;
	logic [IB-1:0]        pit_prev_q, pit_prev_n;
	logic [YB-1:0]        yaw_left_q, yaw_left_n;
	logic [PB-1:0]        pit_left_q, pit_left_n;
	logic                 yaw_dir_q, yaw_dir_n;
	logic                 pit_dir_q, pit_dir_n;
	logic [3:0]           yaw_coil_q, yaw_coil_n;
	logic [3:0]           pit_coil_q, pit_coil_n;
	logic                 out_valid_q;
	tads_pkg::res_t       res_q;

	logic                 busy;
	logic [W-1:0]         left_sel;
	logic signed [W:0]    diff;
	logic [W:0]           diff_neg;
	logic [W-1:0]         mag;
	logic [2*W-1:0]       prod;
	logic [TB-1:0]        quo;
	logic signed [TB-1:0] tilt_c;
	logic                 aim_ok;
	logic [IB-1:0]        idx_c;
	logic signed [4:0]    ym;
	logic signed [4:0]    pm;
	logic [3:0]           yabs;
	logic [2:0]           pabs;
	logic [3:0]           cnt_inc;
	logic [3:0]           dec_n;

	assign busy = (yaw_left_q != '0) || (pit_left_q != '0);
	assign pop  = q_valid && (!out_valid_q || out_ready);

	// tilt = trunc((right - left) / 10), magnitude through a reciprocal multiply
	assign left_sel = (item.kind == tads_pkg::REQ_LEFT && item.in_window) ? item.width : left_q;
	assign diff     = $signed({1'b0, right_q}) - $signed({1'b0, left_sel});
	assign diff_neg = -diff;
	assign mag      = diff[W] ? diff_neg[W-1:0] : diff[W-1:0];
	assign prod     = mag * tads_pkg::Div10Mul;
	assign quo      = TB'(prod[2*W-1:tads_pkg::Div10Shift]);
	assign tilt_c   = diff[W] ? -$signed(quo) : $signed(quo);

	assign aim_ok = (tilt_c >= tads_pkg::AimLo) && (tilt_c <= tads_pkg::AimHi)
		&& (tilt_c != tads_pkg::TiltP1) && (tilt_c != tads_pkg::TiltM1);
	assign idx_c  = tilt_c[IB-1:0] + IB'(tads_pkg::Center);

	assign ym   = 5'(tads_pkg::yaw_tab(idx_c)) - 5'(tads_pkg::yaw_tab(yaw_prev_q));
	assign pm   = 5'(tads_pkg::pitch_tab(idx_c)) - 5'(tads_pkg::pitch_tab(pit_prev_q));
	assign yabs = ym[4] ? 4'(-ym) : ym[3:0];
	assign pabs = pm[4] ? 3'(-pm) : pm[2:0];

	assign cnt_inc = cnt_q + 4'd1;
	assign dec_n   = (cfg.aim_dec == 4'd0) ? 4'd1 : cfg.aim_dec;

	always_comb begin
		right_n    = right_q;
		left_n     = left_q;
		cnt_n      = cnt_q;
		tilt_n     = tilt_q;
		yaw_prev_n = yaw_prev_q;
		pit_prev_n = pit_prev_q;
		yaw_left_n = yaw_left_q;
		pit_left_n = pit_left_q;
		yaw_dir_n  = yaw_dir_q;
		pit_dir_n  = pit_dir_q;
		yaw_coil_n = yaw_coil_q;
		pit_coil_n = pit_coil_q;
		unique case (item.kind)
			tads_pkg::REQ_RIGHT: begin
				if (item.in_window) begin
					right_n = item.width;
				end
			end
			tads_pkg::REQ_LEFT: begin
				if (!busy) begin
					left_n = left_sel;
					tilt_n = tilt_c;
					if (cnt_inc >= dec_n) begin
						cnt_n = '0;
						if (aim_ok) begin
							yaw_dir_n  = ym[4];
							yaw_left_n = cfg.yaw_half ? {yabs, 3'b000} : {1'b0, yabs, 2'b00};
							pit_dir_n  = !pm[4] && (pm != '0);
							pit_left_n = {pabs, 2'b00};
							yaw_prev_n = idx_c;
							pit_prev_n = idx_c;
						end
					end else begin
						cnt_n = cnt_inc;
					end
				end
			end
			tads_pkg::REQ_TICK: begin
				if (yaw_left_q != '0) begin
					if (cfg.yaw_half) begin
						yaw_coil_n = tads_pkg::half_pat(yaw_dir_q, 3'(-yaw_left_q[2:0]));
					end else begin
						yaw_coil_n = tads_pkg::full_pat(yaw_dir_q, 2'(-yaw_left_q[1:0]));
					end
					yaw_left_n = yaw_left_q - 1'b1;
				end else if (pit_left_q != '0) begin
					// pitch direction 1 plays the reverse of the full-step sequence
					pit_coil_n = tads_pkg::full_pat(!pit_dir_q, 2'(-pit_left_q[1:0]));
					pit_left_n = pit_left_q - 1'b1;
				end
			end
			default: begin
				right_n = right_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			right_q     <= '0;
			left_q      <= '0;
			cnt_q       <= '0;
			tilt_q      <= '0;
			yaw_prev_q  <= IB'(tads_pkg::Center);
			pit_prev_q  <= IB'(tads_pkg::Center);
			yaw_left_q  <= '0;
			pit_left_q  <= '0;
			yaw_dir_q   <= 1'b0;
			pit_dir_q   <= 1'b0;
			yaw_coil_q  <= '0;
			pit_coil_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				right_q    <= right_n;
				left_q     <= left_n;
				cnt_q      <= cnt_n;
				tilt_q     <= tilt_n;
				yaw_prev_q <= yaw_prev_n;
				pit_prev_q <= pit_prev_n;
				yaw_left_q <= yaw_left_n;
				pit_left_q <= pit_left_n;
				yaw_dir_q  <= yaw_dir_n;
				pit_dir_q  <= pit_dir_n;
				yaw_coil_q <= yaw_coil_n;
				pit_coil_q <= pit_coil_n;
			end
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q.pad         <= '0;
			res_q.aim_index   <= yaw_prev_n;
			res_q.tilt        <= tilt_n;
			res_q.left_width  <= left_n;
			res_q.right_width <= right_n;
			res_q.busy_res    <= (yaw_left_n != '0) || (pit_left_n != '0);
			res_q.pitch_coils <= pit_coil_n;
			res_q.yaw_coils   <= yaw_coil_n;
		end
	end

	assign out_valid = out_valid_q;
	assign res       = res_q;

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		yaw_prev_q < IB'(tads_pkg::TableSize) && pit_prev_q == yaw_prev_q)
		else $error("aim index out of table");

	a_yaw_first: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && item.kind == tads_pkg::REQ_TICK && yaw_left_q != '0)
		|=> $stable(pit_left_q) && $stable(pit_coil_q)
		&& yaw_left_q == $past(yaw_left_q) - 1'b1)
		else $error("pitch moved while yaw phases pending");

	a_busy_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && item.kind == tads_pkg::REQ_LEFT && busy)
		|=> $stable(left_q) && $stable(cnt_q) && $stable(tilt_q))
		else $error("left echo taken while busy");

endmodule

/* rtl/tilt_aimed_dual_stepper_driver.sv */
// Top level of the tilt-aimed dual stepper driver: config registers, front, queue, back.
// Depends on tads_pkg, tads_front, tads_queue and tads_back.
//
//  channel   dir  handshake                 payload
//  s_axis    in   tvalid/tready             tuser: req_type; tdata: echo_width
//  m_axis    out  tvalid/tready             tdata: coils, busy, widths, tilt, index
//  apb       in   psel/penable/pwrite/...   6 registers at 4*i, pready tied high
//
// One request per cycle sustained while m_axis_tready is high; a result appears the cycle
// after the back end takes a request from the queue.
// The tilt path (subtract, reciprocal multiply, table lookup) is the long path.
// Reset (arst_n low) clears widths, counters and coils and sets both table
// indexes to center; config registers return to their defaults.
// A stalled m_axis fills the queue; s_axis_tready drops only when it is full.
module tilt_aimed_dual_stepper_driver #(
	parameter int QueueDepth = 4
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [1:0]  s_axis_tuser,   // [1:0] req_type
	input  logic [15:0] s_axis_tdata,   // [15:0] echo_width

	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [3:0] yaw_coils, [7:4] pitch_coils, [8] busy_res, [24:9] right_width,
	// [40:25] left_width, [54:41] tilt, [58:55] aim_index, [63:59] zero
	output logic [63:0] m_axis_tdata,

	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	tads_pkg::cfg_t  cfg_q;
	tads_pkg::item_t f_item;
	tads_pkg::item_t q_item;
	tads_pkg::res_t  res;
	logic            push;
	logic            q_full;
	logic            q_valid;
	logic            pop;
	logic [2:0]      reg_idx;
	logic            wr_en;

	// ---------------- configuration registers ----------------
	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.right_min <= 16'd300;
			cfg_q.right_max <= 16'd1500;
			cfg_q.left_min  <= 16'd550;
			cfg_q.left_max  <= 16'd1500;
			cfg_q.aim_dec   <= 4'd4;
			cfg_q.yaw_half  <= 1'b1;
		end else if (wr_en) begin
			unique case (reg_idx)
				tads_pkg::REG_RIGHT_MIN: cfg_q.right_min <= pwdata[15:0];
				tads_pkg::REG_RIGHT_MAX: cfg_q.right_max <= pwdata[15:0];
				tads_pkg::REG_LEFT_MIN:  cfg_q.left_min  <= pwdata[15:0];
				tads_pkg::REG_LEFT_MAX:  cfg_q.left_max  <= pwdata[15:0];
				tads_pkg::REG_AIM_DEC:   cfg_q.aim_dec   <= pwdata[3:0];
				tads_pkg::REG_YAW_HALF:  cfg_q.yaw_half  <= pwdata[0];
				default:                 cfg_q.yaw_half  <= cfg_q.yaw_half;
			endcase
		end
	end

	// readback
	always_comb begin
		unique case (reg_idx)
			tads_pkg::REG_RIGHT_MIN: prdata = {16'd0, cfg_q.right_min};
			tads_pkg::REG_RIGHT_MAX: prdata = {16'd0, cfg_q.right_max};
			tads_pkg::REG_LEFT_MIN:  prdata = {16'd0, cfg_q.left_min};
			tads_pkg::REG_LEFT_MAX:  prdata = {16'd0, cfg_q.left_max};
			tads_pkg::REG_AIM_DEC:   prdata = {28'd0, cfg_q.aim_dec};
			tads_pkg::REG_YAW_HALF:  prdata = {31'd0, cfg_q.yaw_half};
			default:                 prdata = '0;
		endcase
	end

	// ---------------- front: decode and window check ----------------
	tads_front u_front (
		.cfg           (cfg_q),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tdata  (s_axis_tdata),
		.q_full        (q_full),
		.push          (push),
		.item          (f_item)
	);

	// ---------------- request queue ----------------
	tads_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (f_item),
		.full   (q_full),
		.pop    (pop),
		.rvalid (q_valid),
		.rdata  (q_item)
	);

	// ---------------- back: state update and result register ----------------
	tads_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.item      (q_item),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.res       (res)
	);

	assign m_axis_tdata = res;

endmodule
